// File: hw/rtl/setq_pkg.sv
// setq_pkg: shared types and codes for the sorted expiry timer queue.
// No dependencies; used by setq_mem, setq_engine and the top level.
`default_nettype none
package setq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int MAX_RESULTS = 16;

    // request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_ADJUST = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;
    localparam logic [1:0] REQ_TICK   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_EXPIRED = 3'd1;
    localparam logic [2:0] ST_NONE    = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BADID   = 3'd4;

    typedef struct packed {
        logic [31:0] expiry;
        logic [7:0]  ident;
    } t_entry;

    typedef struct packed {
        logic       valid;
        logic [2:0] status;
        logic [7:0] ident;
        logic       last;
    } t_result;

endpackage
`default_nettype wire

// File: hw/rtl/sorted_expiry_timer_queue_top.sv
// sorted_expiry_timer_queue_top: sorted timer list with add/adjust/delete/tick.
// Depends on setq_pkg, setq_engine (which holds setq_mem).
//
//   channel   direction   handshake                    payload
//   request   in          i_in_valid / o_in_stall      req_type, timer_id, expire/current time
//   result    out         o_out_valid / i_out_stall    status, expired_id, is_last
//
// One request is worked at a time. Each entry visited by a scan or moved by a
// shift takes a read state and then a check or write state; the memory is never
// read and written in the same state. A tick reads each expired entry again to output it.
// Reset is synchronous, active low; the queue comes up empty, no clearing pass.
// A stalled result sits in the output register; the engine waits behind it.
`default_nettype none
module sorted_expiry_timer_queue_top
    import setq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_timer_id,
    input  wire logic [31:0] i_expire_time,
    input  wire logic [31:0] i_current_time,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [7:0]       o_expired_id,
    output logic             o_is_last
);

    logic    busy;
    logic    take;
    t_result res;

    logic       r_out_valid;
    logic [2:0] r_status;
    logic [7:0] r_id;
    logic       r_last;

    // engine accepts a request only when idle
    assign o_in_stall = busy;

    setq_engine #(.DEPTH(DEPTH)) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_in_valid),
        .i_req_type     (i_req_type),
        .i_timer_id     (i_timer_id),
        .i_expire_time  (i_expire_time),
        .i_current_time (i_current_time),
        .o_busy         (busy),
        .o_res          (res),
        .i_res_take     (take)
    );

    // output register: loads when empty or being drained this cycle
    assign take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res.valid) begin
            r_status <= res.status;
            r_id     <= res.ident;
            r_last   <= res.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_expired_id = r_id;
    assign o_is_last    = r_last;

    // an accepted request keeps the engine busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> busy)
        else $error("engine idle after accepting a request");

    // results come only from a busy engine
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> busy)
        else $error("result offered while idle");

    // nothing follows the last result of a request
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && take && res.last) |=> !res.valid)
        else $error("result offered after last");

endmodule
`default_nettype wire

// File: hw/rtl/setq_mem.sv
// setq_mem: single-port-write, single-port-read timer entry memory.
// Read data registered. Depends on setq_pkg.
`default_nettype none
module setq_mem
    import setq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output t_entry                        o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire t_entry                   i_wr_data
);

    t_entry mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// File: hw/rtl/setq_engine.sv
// setq_engine: request sequencer; scans and shifts the sorted entry memory.
// Depends on setq_pkg and setq_mem.
`default_nettype none
module setq_engine
    import setq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_timer_id,
    input  wire logic [31:0] i_expire_time,
    input  wire logic [31:0] i_current_time,
    output logic             o_busy,
    output t_result          o_res,
    input  wire logic        i_res_take
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_FIND_RD, S_FIND_CHK, S_DEL_RD, S_DEL_WR, S_POS_RD, S_POS_CHK,
        S_UP_RD, S_UP_WR, S_TK_RD, S_TK_CHK, S_TK_END, S_EM_RD, S_EM_OUT,
        S_SH_RD, S_SH_WR, S_RES
    } t_state;

    t_state      r_state;
    logic [1:0]  r_req;
    logic [7:0]  r_id;
    logic [31:0] r_exp;
    logic [31:0] r_now;
    logic [CW-1:0] r_cnt, r_idx, r_pos, r_n;
    logic [2:0]  r_st;
    logic [7:0]  r_rid;

    logic          rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    t_entry        rd_data, wr_data;
    logic [CW:0]   idx1, idxm1, sum;
    logic          tk_more;

    setq_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign idx1    = {1'b0, r_idx} + 1'b1;
    assign idxm1   = {1'b0, r_idx} - 1'b1;
    assign sum     = {1'b0, r_idx} + {1'b0, r_n};
    assign tk_more = (int'(r_n) < MAX_RESULTS) && (r_n < r_cnt);

    // Reads and writes never target the same cycle, so no forwarding.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_idx[IW-1:0];
        wr_data = rd_data;
        o_res   = '0;
        unique case (r_state)
            S_FIND_RD, S_POS_RD: rd_en = (r_idx < r_cnt);
            S_DEL_RD: begin
                rd_en   = (idx1 < {1'b0, r_cnt});
                rd_addr = idx1[IW-1:0];
            end
            S_DEL_WR, S_UP_WR, S_SH_WR: wr_en = 1'b1;
            S_UP_RD: begin
                if (r_idx == r_pos) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos[IW-1:0];
                    wr_data = '{expiry: r_exp, ident: r_id};
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idxm1[IW-1:0];
                end
            end
            S_TK_RD: begin
                rd_en   = tk_more;
                rd_addr = r_n[IW-1:0];
            end
            S_EM_RD: rd_en = 1'b1;
            S_SH_RD: begin
                rd_en   = (sum < {1'b0, r_cnt});
                rd_addr = sum[IW-1:0];
            end
            S_EM_OUT: o_res = '{valid: 1'b1, status: ST_EXPIRED, ident: rd_data.ident,
                                last: (idx1 == {1'b0, r_n})};
            S_RES: o_res = '{valid: 1'b1, status: r_st, ident: r_rid, last: 1'b1};
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req   <= i_req_type;
                        r_id    <= i_timer_id;
                        r_rid   <= i_timer_id;
                        r_exp   <= i_expire_time;
                        r_now   <= i_current_time;
                        r_idx   <= '0;
                        r_n     <= '0;
                        r_state <= (i_req_type == REQ_TICK) ? S_TK_RD : S_FIND_RD;
                    end
                end
                S_FIND_RD: begin
                    if (r_idx < r_cnt) begin
                        r_state <= S_FIND_CHK;
                    end else if (r_req == REQ_ADD) begin
                        if (r_cnt == CW'(DEPTH)) begin
                            r_st    <= ST_FULL;
                            r_state <= S_RES;
                        end else begin
                            r_idx   <= '0;
                            r_state <= S_POS_RD;
                        end
                    end else begin
                        r_st    <= ST_BADID;
                        r_state <= S_RES;
                    end
                end
                S_FIND_CHK: begin
                    if (rd_data.ident == r_id) begin
                        if (r_req == REQ_ADD) begin
                            r_st    <= ST_BADID;
                            r_state <= S_RES;
                        end else begin
                            r_state <= S_DEL_RD;
                        end
                    end else begin
                        r_idx   <= idx1[CW-1:0];
                        r_state <= S_FIND_RD;
                    end
                end
                S_DEL_RD: begin
                    if (idx1 < {1'b0, r_cnt}) begin
                        r_state <= S_DEL_WR;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                        if (r_req == REQ_ADJUST) begin
                            r_idx   <= '0;
                            r_state <= S_POS_RD;
                        end else begin
                            r_st    <= ST_DONE;
                            r_state <= S_RES;
                        end
                    end
                end
                S_DEL_WR: begin
                    r_idx   <= idx1[CW-1:0];
                    r_state <= S_DEL_RD;
                end
                S_POS_RD: begin
                    if (r_idx < r_cnt) begin
                        r_state <= S_POS_CHK;
                    end else begin
                        r_pos   <= r_idx;
                        r_state <= S_UP_RD;
                    end
                end
                S_POS_CHK: begin
                    if (rd_data.expiry > r_exp) begin
                        r_pos   <= r_idx;
                        r_idx   <= r_cnt;
                        r_state <= S_UP_RD;
                    end else begin
                        r_idx   <= idx1[CW-1:0];
                        r_state <= S_POS_RD;
                    end
                end
                S_UP_RD: begin
                    if (r_idx == r_pos) begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_st    <= ST_DONE;
                        r_state <= S_RES;
                    end else begin
                        r_state <= S_UP_WR;
                    end
                end
                S_UP_WR: begin
                    r_idx   <= idxm1[CW-1:0];
                    r_state <= S_UP_RD;
                end
                S_TK_RD: r_state <= tk_more ? S_TK_CHK : S_TK_END;
                S_TK_CHK: begin
                    if (rd_data.expiry <= r_now) begin
                        r_n     <= r_n + 1'b1;
                        r_state <= S_TK_RD;
                    end else begin
                        r_state <= S_TK_END;
                    end
                end
                S_TK_END: begin
                    if (r_n == '0) begin
                        r_st    <= ST_NONE;
                        r_rid   <= '0;
                        r_state <= S_RES;
                    end else begin
                        r_idx   <= '0;
                        r_state <= S_EM_RD;
                    end
                end
                S_EM_RD: r_state <= S_EM_OUT;
                S_EM_OUT: begin
                    if (i_res_take) begin
                        if (idx1 == {1'b0, r_n}) begin
                            r_idx   <= '0;
                            r_state <= S_SH_RD;
                        end else begin
                            r_idx   <= idx1[CW-1:0];
                            r_state <= S_EM_RD;
                        end
                    end
                end
                S_SH_RD: begin
                    if (sum < {1'b0, r_cnt}) begin
                        r_state <= S_SH_WR;
                    end else begin
                        r_cnt   <= r_cnt - r_n;
                        r_state <= S_IDLE;
                    end
                end
                S_SH_WR: begin
                    r_idx   <= idx1[CW-1:0];
                    r_state <= S_SH_RD;
                end
                S_RES: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
